/* src/lse_pkg.sv */
// Shared constants, codes and handshake structs for the LIFO stack engine.
package lse_pkg;

    // Stack geometry
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    // Stream packing
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LEN  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic              push_wr;      // write word at the top, count up
        logic              pop_dec;      // count down
        logic              rd_top;       // read the top entry, index := top
        logic              rd_next;      // read the entry below the index
        logic              load_out;     // load the result register
        logic              out_from_ram; // result word from the read port
        logic [STAT_W-1:0] out_status;
        logic              out_last;
    } lse_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic idx_zero;
        logic out_free;
    } lse_stat_t;

endpackage

/* src/lse_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/lse_datapath.sv */
// Datapath: fill count, dump index, word store and result register.
module lse_datapath
    import lse_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  lse_cmd_t          cmd,
    output lse_stat_t         stat,
    input  logic [WORD_W-1:0] push_value,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [STAT_W-1:0] out_status,
    output logic [WORD_W-1:0] out_word,
    output logic [CNT_W-1:0]  out_total,
    output logic              out_last
);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              valid_reg, valid_next;
    logic [STAT_W-1:0] status_reg;
    logic [WORD_W-1:0] word_reg;
    logic [CNT_W-1:0]  total_reg;
    logic              last_reg;
    logic [ADDR_W-1:0] top_addr;
    logic [ADDR_W-1:0] raddr;
    logic [WORD_W-1:0] rdata;
    logic              rd_en;

    // Status towards the controller
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CNT_W'(DEPTH));
    assign stat.idx_zero = (idx_reg == '0);
    assign stat.out_free = !valid_reg || m_tready;

    // Fill count and dump index
    assign top_addr = count_reg[ADDR_W-1:0] - 1'b1;

    always_comb begin
        count_next = count_reg;
        if (cmd.push_wr) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.pop_dec) begin
            count_next = count_reg - 1'b1;
        end
        idx_next = idx_reg;
        if (cmd.rd_top) begin
            idx_next = top_addr;
        end else if (cmd.rd_next) begin
            idx_next = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
    end

    // Word store
    assign rd_en = cmd.rd_top || cmd.rd_next;
    assign raddr = cmd.rd_next ? (idx_reg - 1'b1) : top_addr;

    lse_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.push_wr),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (push_value),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Result register: valid flag
    always_comb begin
        valid_next = valid_reg;
        if (cmd.load_out) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Result register: payload
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            status_reg <= cmd.out_status;
            word_reg   <= cmd.out_from_ram ? rdata : '0;
            total_reg  <= count_next;
            last_reg   <= cmd.out_last;
        end
    end

    assign m_tvalid   = valid_reg;
    assign out_status = status_reg;
    assign out_word   = word_reg;
    assign out_total  = total_reg;
    assign out_last   = last_reg;

`ifndef SYNTH
    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");
    a_no_write_full : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push_wr |-> !stat.full)
        else $error("store written while full");
    a_no_read_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_top |-> !stat.empty)
        else $error("top read on empty stack");
    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!valid_reg || m_tready))
        else $error("result register overwritten while held");
`endif

endmodule

/* src/lse_ctrl.sv */
// Controller: command decode and sequencing of reads and dumps.
module lse_ctrl
    import lse_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic [CMD_W-1:0] in_cmd,
    output logic             s_tready,
    input  lse_stat_t        stat,
    output lse_cmd_t         cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SINGLE = 2'd1;
    localparam logic [1:0] S_DUMP   = 2'd2;

    logic [1:0] state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE) && stat.out_free;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_status = STAT_OK;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && stat.out_free) begin
                    unique case (in_cmd)
                        CMD_PUSH: begin
                            cmd.load_out = 1'b1;
                            cmd.out_last = 1'b1;
                            if (stat.full) begin
                                cmd.out_status = STAT_FULL;
                            end else begin
                                cmd.push_wr = 1'b1;
                            end
                        end
                        CMD_POP, CMD_PEEK, CMD_DUMP: begin
                            if (stat.empty) begin
                                cmd.load_out   = 1'b1;
                                cmd.out_last   = 1'b1;
                                cmd.out_status = STAT_EMPTY;
                            end else begin
                                cmd.rd_top = 1'b1;
                                cmd.pop_dec = (in_cmd == CMD_POP);
                                state_next = (in_cmd == CMD_DUMP) ? S_DUMP : S_SINGLE;
                            end
                        end
                        CMD_LEN: begin
                            cmd.load_out = 1'b1;
                            cmd.out_last = 1'b1;
                        end
                        default: begin
                            // unknown commands are consumed without a result
                        end
                    endcase
                end
            end
            S_SINGLE: begin
                if (stat.out_free) begin
                    cmd.load_out     = 1'b1;
                    cmd.out_from_ram = 1'b1;
                    cmd.out_last     = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_DUMP: begin
                if (stat.out_free) begin
                    cmd.load_out     = 1'b1;
                    cmd.out_from_ram = 1'b1;
                    cmd.out_last     = stat.idx_zero;
                    if (stat.idx_zero) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/lifo_stack_engine_top.sv */
// LIFO stack engine: 64-deep stack of words behind stream channels.
//
// Input channel (s_): one command per transaction; s_tdata carries cmd and
// push_value. Push, length and any error return one result in the cycle
// after acceptance. Pop and peek read the word store (registered read), so
// their result passes through the store's read register and then the result
// register. A dump on a non-empty stack returns one result per stored word,
// top first, one per cycle while m_tready is high, with m_tlast set on the
// bottom word. Unknown command codes are accepted and produce no result.
// Commands are handled one at a time: s_tready is high only while the
// controller is idle and the result register is empty or being drained, so
// push, length and error commands sustain one transaction per cycle while
// m_tready is high; pop/peek block new commands until their store read ends.
// When the receiver stalls (m_tready low) the held result stays stable,
// a running dump pauses, and no new command is taken.
// Reset (aresetn low, synchronous) empties the stack and drops any pending
// result; the word store itself is not cleared and needs no clearing pass.
module lifo_stack_engine_top
    import lse_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // cmd[2:0], push_value[34:3]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // status[1:0], word_out[33:2],
                                           // entry_total[40:34]
    output logic                 m_tlast
);

    lse_cmd_t          cmd;
    lse_stat_t         stat;
    logic [STAT_W-1:0] out_status;
    logic [WORD_W-1:0] out_word;
    logic [CNT_W-1:0]  out_total;

    lse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_cmd   (s_tdata[CMD_W-1:0]),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lse_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .push_value (s_tdata[CMD_W +: WORD_W]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_status (out_status),
        .out_word   (out_word),
        .out_total  (out_total),
        .out_last   (m_tlast)
    );

    // Result packing, zero filled to whole bytes
    assign m_tdata = {{(M_TDATA_W - STAT_W - WORD_W - CNT_W){1'b0}},
                      out_total, out_word, out_status};

endmodule
